>>> design/rqhs_pkg.sv
// Package with the command, result and record types of the ring queue with history stack.
`default_nettype none
package rqhs_pkg;

  localparam int QUEUE_DEPTH_DEF   = 128;
  localparam int HISTORY_DEPTH_DEF = 128;

  typedef enum logic [2:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_HPOP   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_SEARCH = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_QEMPTY   = 3'd2,
    ST_HEMPTY   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] name_key;
    logic [15:0] item_number;
    logic [15:0] quantity;
    logic [31:0] entry_date;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        history_dropped;
    logic [63:0] out_name_key;
    logic [15:0] out_number;
    logic [15:0] out_quantity;
    logic [31:0] out_date;
    logic [7:0]  found_position;
    logic [7:0]  queue_count;
    logic [7:0]  history_count;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] number;
    logic [15:0] qty;
    logic [31:0] date;
  } rec_t;

endpackage
`default_nettype wire

>>> design/ring_queue_with_history_stack_unit.sv
// Top level of the ring queue with history stack: sequencer, both stores and the key compare.
// Queue and stack commands: the accepted command runs in S_EXEC, which registers the result.
// Search: the single key comparator checks one queue entry per cycle from the head, and a hit
// reports its position p while a miss reports after all queue_count entries are checked.
// No new command is taken while busy; busy stays high until the result strobe.
// Synchronous reset empties the queue and the history; the store contents are kept.
`default_nettype none
module ring_queue_with_history_stack_unit
  import rqhs_pkg::*;
#(
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic start,
  output       logic busy,
  input  wire  in_t  in_item,
  output       logic out_strobe,
  output       out_t out_item
);

  localparam int QA  = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int HA  = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);

  function automatic logic [QA-1:0] q_inc(input logic [QA-1:0] p);
    return (p == QA'(QUEUE_DEPTH - 1)) ? '0 : QA'(p + 1'b1);
  endfunction

  rec_t q_mem [QUEUE_DEPTH];
  rec_t h_mem [HISTORY_DEPTH];

  state_t          state_r, state_nxt;
  in_t             cmd_r, cmd_nxt;
  logic [QA-1:0]   head_r, head_nxt;
  logic [QA-1:0]   tail_r, tail_nxt;
  logic [QCW-1:0]  q_fill_r, q_fill_nxt;
  logic [HCW-1:0]  h_fill_r, h_fill_nxt;
  logic [QA-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [QCW-1:0]  scan_i_r, scan_i_nxt;
  out_t            out_r, out_nxt;
  logic            strobe_r, strobe_nxt;

  rec_t            q_rdata_r, h_rdata_r;
  logic [QA-1:0]   q_raddr;
  logic [HA-1:0]   h_raddr;
  logic            q_we, h_we;
  rec_t            q_wdata;
  logic [HA-1:0]   h_waddr;
  logic            key_hit;
  logic [QCW-1:0]  scan_i_inc;

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  assign key_hit    = (q_rdata_r.key == cmd_r.name_key);
  assign scan_i_inc = QCW'(scan_i_r + 1'b1);

  always_comb begin
    case (state_r)
      S_IDLE:  q_raddr = head_r;
      S_EXEC:  q_raddr = head_r;
      default: q_raddr = q_inc(scan_ptr_r);
    endcase
    h_raddr = (h_fill_r == '0) ? '0 : HA'(h_fill_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    q_rdata_r <= q_mem[q_raddr];
    h_rdata_r <= h_mem[h_raddr];
    if (q_we) begin
      q_mem[tail_r] <= q_wdata;
    end
    if (h_we) begin
      h_mem[h_waddr] <= q_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      q_fill_r <= '0;
      h_fill_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      q_fill_r <= q_fill_nxt;
      h_fill_r <= h_fill_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_ptr_r <= scan_ptr_nxt;
    scan_i_r   <= scan_i_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    q_fill_nxt   = q_fill_r;
    h_fill_nxt   = h_fill_r;
    scan_ptr_nxt = scan_ptr_r;
    scan_i_nxt   = scan_i_r;
    out_nxt      = out_r;
    strobe_nxt   = 1'b0;
    q_we         = 1'b0;
    h_we         = 1'b0;
    h_waddr      = h_fill_r[HA-1:0];
    q_wdata      = '{key:    cmd_r.name_key,
                     number: cmd_r.item_number,
                     qty:    cmd_r.quantity,
                     date:   cmd_r.entry_date};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_nxt        = '0;
        out_nxt.status = ST_OK;
        state_nxt      = S_IDLE;
        strobe_nxt     = 1'b1;
        case (cmd_r.opcode)
          OP_ENQ: begin
            if (q_fill_r == QCW'(QUEUE_DEPTH)) begin
              out_nxt.status = ST_FULL;
            end else begin
              q_we       = 1'b1;
              tail_nxt   = q_inc(tail_r);
              q_fill_nxt = QCW'(q_fill_r + 1'b1);
            end
          end
          OP_DEQ: begin
            if (q_fill_r == '0) begin
              out_nxt.status = ST_QEMPTY;
            end else begin
              head_nxt             = q_inc(head_r);
              q_fill_nxt           = QCW'(q_fill_r - 1'b1);
              out_nxt.out_name_key = q_rdata_r.key;
              out_nxt.out_number   = q_rdata_r.number;
              out_nxt.out_quantity = q_rdata_r.qty;
              out_nxt.out_date     = q_rdata_r.date;
              if (h_fill_r == HCW'(HISTORY_DEPTH)) begin
                out_nxt.history_dropped = 1'b1;
              end else begin
                h_we       = 1'b1;
                h_fill_nxt = HCW'(h_fill_r + 1'b1);
              end
            end
          end
          OP_HPOP: begin
            if (h_fill_r == '0) begin
              out_nxt.status = ST_HEMPTY;
            end else begin
              h_fill_nxt           = HCW'(h_fill_r - 1'b1);
              out_nxt.out_name_key = h_rdata_r.key;
              out_nxt.out_number   = h_rdata_r.number;
              out_nxt.out_quantity = h_rdata_r.qty;
              out_nxt.out_date     = h_rdata_r.date;
            end
          end
          OP_CLEAR: begin
            head_nxt   = '0;
            tail_nxt   = '0;
            q_fill_nxt = '0;
          end
          OP_SEARCH: begin
            if (q_fill_r == '0) begin
              out_nxt.status = ST_QEMPTY;
            end else begin
              scan_ptr_nxt = head_r;
              scan_i_nxt   = '0;
              state_nxt    = S_SCAN;
              strobe_nxt   = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (key_hit) begin
          out_nxt.status         = ST_OK;
          out_nxt.found_position = 8'(scan_i_inc);
          state_nxt              = S_IDLE;
          strobe_nxt             = 1'b1;
        end else if (scan_i_inc == q_fill_r) begin
          out_nxt.status = ST_NOTFOUND;
          state_nxt      = S_IDLE;
          strobe_nxt     = 1'b1;
        end else begin
          scan_i_nxt   = scan_i_inc;
          scan_ptr_nxt = q_inc(scan_ptr_r);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.queue_count   = 8'(q_fill_nxt);
    out_nxt.history_count = 8'(h_fill_nxt);
  end

endmodule
`default_nettype wire

>>> design/rqhs_checker.sv
// Port-level checker for the ring queue with history stack, bound to the top level.
`default_nettype none
module rqhs_checker
  import rqhs_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while still busy");

  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result transfer");

  a_fail_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |->
      (out_item.out_name_key == 64'd0 && out_item.found_position == 8'd0))
    else $error("failed command returned record or position data");

endmodule

bind ring_queue_with_history_stack_unit rqhs_checker u_rqhs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
`default_nettype wire
